### rtl/hpd_pkg.sv
// Shared types, code tables and trie construction for the HPACK Huffman decoder.
`timescale 1ns / 1ps
`default_nettype none
package hpd_pkg;

  localparam int NodeCount = 256;
  localparam int RomDepth  = 2 * NodeCount;
  localparam int PadMax    = 7;
  localparam int SymCount  = 257;

  typedef logic [9:0]              hpd_child_t;  // [9] leaf, [8:0] symbol or node
  typedef hpd_child_t [RomDepth-1:0] hpd_trie_t;  // indexed {node, bit}
  typedef logic [NodeCount-1:0]    hpd_end_t;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_DONE = 2'd1,
    ST_BAD  = 2'd2
  } hpd_status_t;

  typedef struct packed {
    logic [7:0]  symbol;
    logic        has_symbol;
    hpd_status_t status;
    logic        run_last;
  } hpd_res_t;

  localparam logic [4:0] HUFF_LEN [SymCount] = '{
    5'd13, 5'd23, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd24, 5'd30, 5'd28,
    5'd28, 5'd30, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd30, 5'd28,
    5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd6,  5'd10, 5'd10, 5'd12,
    5'd13, 5'd6,  5'd8,  5'd11, 5'd10, 5'd10, 5'd8,  5'd11, 5'd8,  5'd6,  5'd6,  5'd6,
    5'd5,  5'd5,  5'd5,  5'd6,  5'd6,  5'd6,  5'd6,  5'd6,  5'd6,  5'd6,  5'd7,  5'd8,
    5'd15, 5'd6,  5'd12, 5'd10, 5'd13, 5'd6,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,
    5'd7,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,
    5'd7,  5'd7,  5'd7,  5'd7,  5'd8,  5'd7,  5'd8,  5'd13, 5'd19, 5'd13, 5'd14, 5'd6,
    5'd15, 5'd5,  5'd6,  5'd5,  5'd6,  5'd5,  5'd6,  5'd6,  5'd6,  5'd5,  5'd7,  5'd7,
    5'd6,  5'd6,  5'd6,  5'd5,  5'd6,  5'd7,  5'd6,  5'd5,  5'd5,  5'd6,  5'd7,  5'd7,
    5'd7,  5'd7,  5'd7,  5'd15, 5'd11, 5'd14, 5'd13, 5'd28, 5'd20, 5'd22, 5'd20, 5'd20,
    5'd22, 5'd22, 5'd22, 5'd23, 5'd22, 5'd23, 5'd23, 5'd23, 5'd23, 5'd23, 5'd24, 5'd23,
    5'd24, 5'd24, 5'd22, 5'd23, 5'd24, 5'd23, 5'd23, 5'd23, 5'd23, 5'd21, 5'd22, 5'd23,
    5'd22, 5'd23, 5'd23, 5'd24, 5'd22, 5'd21, 5'd20, 5'd22, 5'd22, 5'd23, 5'd23, 5'd21,
    5'd23, 5'd22, 5'd22, 5'd24, 5'd21, 5'd22, 5'd23, 5'd23, 5'd21, 5'd21, 5'd22, 5'd21,
    5'd23, 5'd22, 5'd23, 5'd23, 5'd20, 5'd22, 5'd22, 5'd22, 5'd23, 5'd22, 5'd22, 5'd23,
    5'd26, 5'd26, 5'd20, 5'd19, 5'd22, 5'd23, 5'd22, 5'd25, 5'd26, 5'd26, 5'd26, 5'd27,
    5'd27, 5'd26, 5'd24, 5'd25, 5'd19, 5'd21, 5'd26, 5'd27, 5'd27, 5'd26, 5'd27, 5'd24,
    5'd21, 5'd21, 5'd26, 5'd26, 5'd28, 5'd27, 5'd27, 5'd27, 5'd20, 5'd24, 5'd20, 5'd21,
    5'd22, 5'd21, 5'd21, 5'd23, 5'd22, 5'd22, 5'd25, 5'd25, 5'd24, 5'd24, 5'd26, 5'd23,
    5'd26, 5'd27, 5'd26, 5'd26, 5'd27, 5'd27, 5'd27, 5'd27, 5'd27, 5'd28, 5'd27, 5'd27,
    5'd27, 5'd27, 5'd27, 5'd26, 5'd30
  };

  localparam logic [29:0] HUFF_BITS [SymCount] = '{
    30'h1ff8,     30'h7fffd8,   30'hfffffe2,  30'hfffffe3,  30'hfffffe4,  30'hfffffe5,
    30'hfffffe6,  30'hfffffe7,  30'hfffffe8,  30'hffffea,   30'h3ffffffc, 30'hfffffe9,
    30'hfffffea,  30'h3ffffffd, 30'hfffffeb,  30'hfffffec,  30'hfffffed,  30'hfffffee,
    30'hfffffef,  30'hffffff0,  30'hffffff1,  30'hffffff2,  30'h3ffffffe, 30'hffffff3,
    30'hffffff4,  30'hffffff5,  30'hffffff6,  30'hffffff7,  30'hffffff8,  30'hffffff9,
    30'hffffffa,  30'hffffffb,  30'h14,       30'h3f8,      30'h3f9,      30'hffa,
    30'h1ff9,     30'h15,       30'hf8,       30'h7fa,      30'h3fa,      30'h3fb,
    30'hf9,       30'h7fb,      30'hfa,       30'h16,       30'h17,       30'h18,
    30'h0,        30'h1,        30'h2,        30'h19,       30'h1a,       30'h1b,
    30'h1c,       30'h1d,       30'h1e,       30'h1f,       30'h5c,       30'hfb,
    30'h7ffc,     30'h20,       30'hffb,      30'h3fc,      30'h1ffa,     30'h21,
    30'h5d,       30'h5e,       30'h5f,       30'h60,       30'h61,       30'h62,
    30'h63,       30'h64,       30'h65,       30'h66,       30'h67,       30'h68,
    30'h69,       30'h6a,       30'h6b,       30'h6c,       30'h6d,       30'h6e,
    30'h6f,       30'h70,       30'h71,       30'h72,       30'hfc,       30'h73,
    30'hfd,       30'h1ffb,     30'h7fff0,    30'h1ffc,     30'h3ffc,     30'h22,
    30'h7ffd,     30'h3,        30'h23,       30'h4,        30'h24,       30'h5,
    30'h25,       30'h26,       30'h27,       30'h6,        30'h74,       30'h75,
    30'h28,       30'h29,       30'h2a,       30'h7,        30'h2b,       30'h76,
    30'h2c,       30'h8,        30'h9,        30'h2d,       30'h77,       30'h78,
    30'h79,       30'h7a,       30'h7b,       30'h7ffe,     30'h7fc,      30'h3ffd,
    30'h1ffd,     30'hffffffc,  30'hfffe6,    30'h3fffd2,   30'hfffe7,    30'hfffe8,
    30'h3fffd3,   30'h3fffd4,   30'h3fffd5,   30'h7fffd9,   30'h3fffd6,   30'h7fffda,
    30'h7fffdb,   30'h7fffdc,   30'h7fffdd,   30'h7fffde,   30'hffffeb,   30'h7fffdf,
    30'hffffec,   30'hffffed,   30'h3fffd7,   30'h7fffe0,   30'hffffee,   30'h7fffe1,
    30'h7fffe2,   30'h7fffe3,   30'h7fffe4,   30'h1fffdc,   30'h3fffd8,   30'h7fffe5,
    30'h3fffd9,   30'h7fffe6,   30'h7fffe7,   30'hffffef,   30'h3fffda,   30'h1fffdd,
    30'hfffe9,    30'h3fffdb,   30'h3fffdc,   30'h7fffe8,   30'h7fffe9,   30'h1fffde,
    30'h7fffea,   30'h3fffdd,   30'h3fffde,   30'hfffff0,   30'h1fffdf,   30'h3fffdf,
    30'h7fffeb,   30'h7fffec,   30'h1fffe0,   30'h1fffe1,   30'h3fffe0,   30'h1fffe2,
    30'h7fffed,   30'h3fffe1,   30'h7fffee,   30'h7fffef,   30'hfffea,    30'h3fffe2,
    30'h3fffe3,   30'h3fffe4,   30'h7ffff0,   30'h3fffe5,   30'h3fffe6,   30'h7ffff1,
    30'h3ffffe0,  30'h3ffffe1,  30'hfffeb,    30'h7fff1,    30'h3fffe7,   30'h7ffff2,
    30'h3fffe8,   30'h1ffffec,  30'h3ffffe2,  30'h3ffffe3,  30'h3ffffe4,  30'h7ffffde,
    30'h7ffffdf,  30'h3ffffe5,  30'hfffff1,   30'h1ffffed,  30'h7fff2,    30'h1fffe3,
    30'h3ffffe6,  30'h7ffffe0,  30'h7ffffe1,  30'h3ffffe7,  30'h7ffffe2,  30'hfffff2,
    30'h1fffe4,   30'h1fffe5,   30'h3ffffe8,  30'h3ffffe9,  30'hffffffd,  30'h7ffffe3,
    30'h7ffffe4,  30'h7ffffe5,  30'hfffec,    30'hfffff3,   30'hfffed,    30'h1fffe6,
    30'h3fffe9,   30'h1fffe7,   30'h1fffe8,   30'h7ffff3,   30'h3fffea,   30'h3fffeb,
    30'h1ffffee,  30'h1ffffef,  30'hfffff4,   30'hfffff5,   30'h3ffffea,  30'h7ffff4,
    30'h3ffffeb,  30'h7ffffe6,  30'h3ffffec,  30'h3ffffed,  30'h7ffffe7,  30'h7ffffe8,
    30'h7ffffe9,  30'h7ffffea,  30'h7ffffeb,  30'hffffffe,  30'h7ffffec,  30'h7ffffed,
    30'h7ffffee,  30'h7ffffef,  30'h7fffff0,  30'h3ffffee,  30'h3fffffff
  };

  // Child table: zero means absent, bit 9 marks a leaf holding the symbol.
  function automatic hpd_trie_t hpd_build_trie();
    hpd_trie_t  t;
    logic [8:0] used;
    logic [7:0] node;
    logic [9:0] s;
    logic [4:0] k;
    logic [8:0] idx;
    t    = '0;
    used = 9'd1;
    for (s = 10'd0; s < 10'(SymCount); s = s + 10'd1) begin
      node = 8'd0;
      for (k = HUFF_LEN[s[8:0]]; k > 5'd0; k = k - 5'd1) begin
        idx = {node, HUFF_BITS[s[8:0]][k - 5'd1]};
        if (k == 5'd1) begin
          t[idx] = {1'b1, s[8:0]};
        end else begin
          if (t[idx] == '0) begin
            t[idx] = {2'b00, used[7:0]};
            used   = used + 9'd1;
          end
          node = t[idx][7:0];
        end
      end
    end
    return t;
  endfunction

  // Nodes where a string may end: the root and the all-ones path up to PadMax bits.
  function automatic hpd_end_t hpd_build_end_ok(input hpd_trie_t t);
    hpd_end_t   e;
    logic [7:0] node;
    hpd_child_t c;
    logic       stop;
    e    = '0;
    e[0] = 1'b1;
    node = 8'd0;
    stop = 1'b0;
    for (int d = 0; d < PadMax; d++) begin
      if (!stop) begin
        c = t[{node, 1'b1}];
        if (c == '0 || c[9]) begin
          stop = 1'b1;
        end else begin
          node    = c[7:0];
          e[node] = 1'b1;
        end
      end
    end
    return e;
  endfunction

  localparam hpd_trie_t TRIE_ROM = hpd_build_trie();
  localparam hpd_end_t  END_OK   = hpd_build_end_ok(TRIE_ROM);

endpackage
`default_nettype wire

### rtl/hpack_huffman_decoder_core.sv
// HPACK Huffman decoder top level: bit-serial walk over a synchronous trie ROM.
// Timing: a data byte walks one code bit per cycle, one trie ROM read per code bit; a new beat
//   is taken only once the last one is through its walk and its results, if any, are in the
//   queue; results drain meanwhile.
// Reset: synchronous rst puts the walk at the root, padding acceptable, and empties the queue.
`timescale 1ns / 1ps
`default_nettype none
module hpack_huffman_decoder_core
  import hpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] code_byte,
  input  logic       byte_present,
  input  logic       end_of_string,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] symbol,
  output logic       has_symbol,
  output logic [1:0] status,
  output logic       run_last
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;

  state_t      state;
  logic [7:0]  node;
  logic        pad_ok;
  logic [7:0]  byte_q;
  logic        eos_q;
  logic [2:0]  bit_idx;
  logic [1:0]  nsym;
  logic [7:0]  syms [2];
  hpd_status_t fin_status;

  hpd_child_t  rom_q;
  logic [8:0]  rom_addr;
  logic        leaf;
  logic        step_err;
  logic [7:0]  cur;
  logic [1:0]  nsym_next;

  logic        q_load;
  logic        q_empty;
  logic [1:0]  q_count;
  hpd_res_t    q_a;
  hpd_res_t    q_b;
  hpd_res_t    q_head;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    leaf      = rom_q[9];
    step_err  = (rom_q == '0) || (leaf && (rom_q[8] || nsym == 2'd2));
    cur       = leaf ? 8'd0 : rom_q[7:0];
    nsym_next = nsym + {1'b0, leaf};
    rom_addr  = (state == S_WALK) ? {cur, byte_q[bit_idx - 3'd1]} : {node, code_byte[7]};
  end

  always_ff @(posedge clk) begin
    rom_q <= TRIE_ROM[rom_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      node   <= 8'd0;
      pad_ok <= 1'b1;
      nsym   <= 2'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            nsym <= 2'd0;
            if (byte_present) begin
              byte_q  <= code_byte;
              eos_q   <= end_of_string;
              bit_idx <= 3'd7;
              state   <= S_WALK;
            end else if (end_of_string) begin
              fin_status <= pad_ok ? ST_DONE : ST_BAD;
              node       <= 8'd0;
              pad_ok     <= 1'b1;
              state      <= S_DONE;
            end
          end
        end
        S_WALK: begin
          if (step_err) begin
            nsym       <= 2'd0;
            fin_status <= ST_BAD;
            node       <= 8'd0;
            pad_ok     <= 1'b1;
            state      <= S_DONE;
          end else begin
            if (leaf) begin
              syms[nsym[0]] <= rom_q[7:0];
            end
            nsym <= nsym_next;
            if (bit_idx == 3'd0) begin
              if (eos_q) begin
                fin_status <= END_OK[cur] ? ST_DONE : ST_BAD;
                node       <= 8'd0;
                pad_ok     <= 1'b1;
                state      <= S_DONE;
              end else begin
                fin_status <= ST_BUSY;
                node       <= cur;
                pad_ok     <= END_OK[cur];
                state      <= (nsym_next != 2'd0) ? S_DONE : S_IDLE;
              end
            end else begin
              bit_idx <= bit_idx - 3'd1;
            end
          end
        end
        S_DONE: begin
          if (q_empty) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    q_load           = (state == S_DONE) && q_empty;
    q_count          = (nsym == 2'd2) ? 2'd2 : 2'd1;
    q_a.has_symbol   = (nsym != 2'd0);
    q_a.symbol       = q_a.has_symbol ? syms[0] : 8'd0;
    q_a.run_last     = (nsym != 2'd2);
    q_a.status       = q_a.run_last ? fin_status : ST_BUSY;
    q_b.has_symbol   = 1'b1;
    q_b.symbol       = syms[1];
    q_b.run_last     = 1'b1;
    q_b.status       = fin_status;
  end

  hpd_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .load       (q_load),
    .load_count (q_count),
    .load_a     (q_a),
    .load_b     (q_b),
    .empty      (q_empty),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .head       (q_head)
  );

  assign symbol     = q_head.symbol;
  assign has_symbol = q_head.has_symbol;
  assign status     = q_head.status;
  assign run_last   = q_head.run_last;

endmodule
`default_nettype wire

### rtl/hpd_outq.sv
// Two-entry result queue between the trie walker and the output channel.
`timescale 1ns / 1ps
`default_nettype none
module hpd_outq
  import hpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic [1:0] load_count,
  input  hpd_res_t   load_a,
  input  hpd_res_t   load_b,
  output logic       empty,
  output logic       out_valid,
  input  logic       out_ready,
  output hpd_res_t   head
);

  hpd_res_t   slot0;
  hpd_res_t   slot1;
  logic [1:0] count;

  assign empty     = (count == 2'd0);
  assign out_valid = !empty;
  assign head      = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= load_count;
      slot0 <= load_a;
      slot1 <= load_b;
    end else if (out_valid && out_ready) begin
      count <= count - 2'd1;
      slot0 <= slot1;
    end
  end

endmodule
`default_nettype wire

### rtl/hpd_checker.sv
// Port-level checks for the HPACK Huffman decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module hpd_port_checks
  import hpd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       byte_present,
  input logic       end_of_string,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] symbol,
  input logic       has_symbol,
  input logic [1:0] status,
  input logic       run_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(symbol) && $stable(status)
      && $stable(has_symbol) && $stable(run_last))
    else $error("result beat changed while stalled");

  a_empty_sym_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_symbol |-> symbol == 8'd0 && run_last)
    else $error("empty result carries a symbol or is not last");

  a_final_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_BUSY |-> run_last)
    else $error("final status on a non-last beat");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_BUSY || status == ST_DONE || status == ST_BAD)
    else $error("undefined status code");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (byte_present || end_of_string) |=> !in_ready)
    else $error("input taken on back-to-back cycles");

endmodule

bind hpack_huffman_decoder_core hpd_port_checks u_hpd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .byte_present  (byte_present),
  .end_of_string (end_of_string),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .symbol        (symbol),
  .has_symbol    (has_symbol),
  .status        (status),
  .run_last      (run_last)
);
`default_nettype wire
